### rtl/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error("implication");
`define CHK_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error("next");
`endif

### rtl/tdes_cmac_pkg.sv
package tdes_cmac_pkg;

  typedef enum logic [1:0] {
    RegKeyOne   = 2'd0,
    RegKeyTwo   = 2'd1,
    RegKeyThree = 2'd2,
    RegMode     = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StSubkey,
    StCrypt,
    StOut
  } eng_state_e;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  cnt;
    logic        last;
  } blk_t;

  localparam logic [63:0] Rb     = 64'h1B;
  localparam logic [7:0]  PadByte = 8'h80;

  localparam int Ip [64] = '{58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,57,49,41,33,25,17,9,1,
    59,51,43,35,27,19,11,3,61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
  localparam int Fp [64] = '{40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,36,4,44,12,52,20,60,28,
    35,3,43,11,51,19,59,27,34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
  localparam int Ex [48] = '{32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,
    14,15,16,17,16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,
    30,31,32,1};
  localparam int Pm [32] = '{16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
  localparam int Pc1 [56] = '{57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,
    59,51,43,35,27,19,11,3,60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,
    30,22,14,6,61,53,45,37,29,21,13,5,28,20,12,4};
  localparam int Pc2 [48] = '{14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,
    26,8,16,7,27,20,13,2,41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,
    34,53,46,42,50,36,29,32};
  localparam int Rot [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
  localparam logic [3:0] Sb [8][64] = '{
   '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
     4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
   '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
     0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
   '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
     13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
   '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
     10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
   '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
     4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
   '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
     9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
   '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
     1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
   '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
     7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  function automatic logic [63:0] f_ip(input logic [63:0] x, input logic inv);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = x[64 - (inv ? Fp[i] : Ip[i])];
    return r;
  endfunction

  function automatic logic [55:0] f_pc1(input logic [63:0] k);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) r[55-i] = k[64-Pc1[i]];
    return r;
  endfunction

  function automatic logic [47:0] f_pc2(input logic [55:0] cd);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) r[47-i] = cd[56-Pc2[i]];
    return r;
  endfunction

  function automatic logic [27:0] f_rol(input logic [27:0] v, input int s);
    return (s == 2) ? {v[25:0], v[27:26]} : {v[26:0], v[27]};
  endfunction

  function automatic logic [27:0] f_ror(input logic [27:0] v, input int s);
    return (s == 2) ? {v[1:0], v[27:2]} : {v[0], v[27:1]};
  endfunction

  function automatic logic [31:0] f_round(input logic [31:0] r, input logic [47:0] k);
    logic [47:0] x;
    logic [31:0] o;
    logic [31:0] p;
    logic [5:0]  s6;
    for (int i = 0; i < 48; i++) x[47-i] = r[32-Ex[i]];
    x = x ^ k;
    for (int i = 0; i < 8; i++) begin
      s6 = x[47-6*i -: 6];
      o[31-4*i -: 4] = Sb[i][{s6[5], s6[0], s6[4:1]}];
    end
    for (int i = 0; i < 32; i++) p[31-i] = o[32-Pm[i]];
    return p;
  endfunction

  function automatic logic [63:0] f_dbl(input logic [63:0] v);
    return {v[62:0], 1'b0} ^ (v[63] ? Rb : 64'd0);
  endfunction

endpackage

### rtl/tdes_cmac_engine_unit.sv
// tdes_cmac_engine_unit: CMAC over TDES EDE, 64-bit blocks.
// Input channel: push/full carries block_data_i, byte_count_i, is_last_i.
// A two-entry queue pads last blocks; the back end runs one DES round a cycle.
// Result channel: empty/pop carries mac_o, one transaction per message.
// Configuration channel: cfg_valid/cfg_ready, index and data; write only when idle.
// Each block takes three DES passes of 16 rounds each; the back end takes the
// next block from the queue in its idle state, only once the last one is done.
// The first block of a message is preceded by a TDES encryption of zero for the subkeys.
// The mac is registered and becomes valid when the last block's third pass ends.
// Reset clears keys, subkeys, chain value, the queue and the mac valid flag.
// A stalled receiver holds the mac; the back end keeps taking non-last blocks
// but holds a last block in the queue until the mac is popped, and the input
// then stalls once the two queue entries are full.
module tdes_cmac_engine_unit import tdes_cmac_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [63:0] block_data_i,
  input  logic [3:0]  byte_count_i,
  input  logic        is_last_i,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] mac_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] k1_q, k2_q, k3_q;
  logic        mode_q, bv, br, rv;
  blk_t        b;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k1_q <= '0; k2_q <= '0; k3_q <= '0; mode_q <= 1'b0;
    end else if (cfg_valid) begin
      unique case (reg_idx_e'(cfg_index))
        RegKeyOne:   k1_q <= cfg_data;
        RegKeyTwo:   k2_q <= cfg_data;
        RegKeyThree: k3_q <= cfg_data;
        RegMode:     mode_q <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tdes_cmac_front u_front (
    .clk_i, .rst_ni, .push, .full, .block_data_i, .byte_count_i, .is_last_i,
    .blk_vld_o(bv), .blk_rdy_i(br), .blk_o(b)
  );

  tdes_cmac_back u_back (
    .clk_i, .rst_ni, .key_one_i(k1_q), .key_two_i(k2_q), .key_three_i(k3_q),
    .three_key_mode_i(mode_q), .blk_vld_i(bv), .blk_rdy_o(br), .blk_i(b),
    .res_vld_o(rv), .res_rdy_i(pop), .res_o(mac_o)
  );

  assign empty = !rv;

endmodule

### rtl/tdes_cmac_front.sv
module tdes_cmac_front import tdes_cmac_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [63:0] block_data_i,
  input  logic [3:0]  byte_count_i,
  input  logic        is_last_i,
  output logic        blk_vld_o,
  input  logic        blk_rdy_i,
  output blk_t        blk_o
);

  blk_t       mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, rp_q;
  logic       wr, rd;
  logic [3:0] n;
  logic [63:0] keep, padded;

  always_comb begin
    n = (byte_count_i > 4'd8) ? 4'd8 : byte_count_i;
    keep = (n == 4'd0) ? 64'd0 : ~(64'hFFFF_FFFF_FFFF_FFFF >> {n[2:0], 3'b000});
    if (n == 4'd8) keep = '1;
    padded = (block_data_i & keep) | (n == 4'd8 ? 64'd0 :
             ({56'd0, PadByte} << {3'd7 - n[2:0], 3'b000}));
  end

  assign full      = cnt_q == 2'd2;
  assign blk_vld_o = cnt_q != 2'd0;
  assign blk_o     = mem_q[rp_q];
  assign wr        = push && !full;
  assign rd        = blk_vld_o && blk_rdy_i;
  assign cnt_d     = cnt_q + {1'b0, wr} - {1'b0, rd};

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q].data <= is_last_i ? padded : block_data_i;
      mem_q[wp_q].cnt  <= is_last_i ? n : 4'd8;
      mem_q[wp_q].last <= is_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
    end
  end

endmodule

### rtl/tdes_cmac_back.sv
module tdes_cmac_back import tdes_cmac_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [63:0] key_one_i,
  input  logic [63:0] key_two_i,
  input  logic [63:0] key_three_i,
  input  logic        three_key_mode_i,
  input  logic        blk_vld_i,
  output logic        blk_rdy_o,
  input  blk_t        blk_i,
  output logic        res_vld_o,
  input  logic        res_rdy_i,
  output logic [63:0] res_o
);

  eng_state_e  st_q, st_d;
  logic [3:0]  rnd_q;
  logic [1:0]  pass_q;
  logic [27:0] c_q, d_q, c_n, d_n, c_s, d_s;
  logic [31:0] l_q, r_q, rf;
  logic [63:0] cv_q, k1_q, k2_q, res_q, blk_q, fpv, k1n, k2n, ldv, ipv, key_sel;
  logic        inm_q, last_q, cnt8_q, resv_q, dec, fin, done, hold, take, ld;
  logic [55:0] pc1v;
  logic [47:0] kn;

  always_comb begin
    unique case (pass_q)
      2'd0:    key_sel = key_one_i;
      2'd1:    key_sel = key_two_i;
      default: key_sel = three_key_mode_i ? key_three_i : key_one_i;
    endcase
  end

  assign dec       = pass_q == 2'd1;
  assign fin       = (st_q != StIdle) && (rnd_q == 4'd15);
  assign done      = fin && (pass_q == 2'd2);
  assign hold      = blk_i.last && resv_q;
  assign res_vld_o = resv_q;
  assign res_o     = res_q;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle:   if (blk_vld_i && !hold) st_d = inm_q ? StCrypt : StSubkey;
      StSubkey: if (done) st_d = StCrypt;
      StCrypt:  if (done) st_d = StIdle;
      default:  st_d = StIdle;
    endcase
  end

  always_comb begin
    blk_rdy_o = (st_q == StIdle) && !hold;
    take      = blk_rdy_o && blk_vld_i;
    ld        = take || (fin && !(done && st_q == StCrypt));
  end

  always_comb begin
    pc1v = f_pc1(key_sel);
    c_n  = pc1v[55:28];
    d_n  = pc1v[27:0];
    if (dec) begin
      c_s = (rnd_q == 4'd0) ? c_n : c_q;
      d_s = (rnd_q == 4'd0) ? d_n : d_q;
    end else begin
      c_s = f_rol((rnd_q == 4'd0) ? c_n : c_q, Rot[rnd_q]);
      d_s = f_rol((rnd_q == 4'd0) ? d_n : d_q, Rot[rnd_q]);
    end
    kn  = f_pc2({c_s, d_s});
    rf  = l_q ^ f_round(r_q, kn);
    fpv = f_ip({rf, r_q}, 1'b1);
    k1n = f_dbl(fpv);
    k2n = f_dbl(k1n);
  end

  always_comb begin
    if (st_q == StIdle) begin
      ldv = inm_q ? (cv_q ^ blk_i.data ^
            (blk_i.last ? (blk_i.cnt == 4'd8 ? k1_q : k2_q) : 64'd0)) : 64'd0;
    end else if (!done) begin
      ldv = fpv;
    end else begin
      ldv = blk_q ^ (last_q ? (cnt8_q ? k1n : k2n) : 64'd0);
    end
    ipv = f_ip(ldv, 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StIdle;
      rnd_q  <= '0;
      pass_q <= '0;
      c_q    <= '0;
      d_q    <= '0;
      l_q    <= '0;
      r_q    <= '0;
      cv_q   <= '0;
      k1_q   <= '0;
      k2_q   <= '0;
      res_q  <= '0;
      blk_q  <= '0;
      inm_q  <= 1'b0;
      last_q <= 1'b0;
      cnt8_q <= 1'b0;
      resv_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (take) begin
        rnd_q  <= '0;
        pass_q <= '0;
        blk_q  <= blk_i.data;
        last_q <= blk_i.last;
        cnt8_q <= blk_i.cnt == 4'd8;
      end else if (st_q != StIdle) begin
        rnd_q <= rnd_q + 4'd1;
        if (fin) pass_q <= (pass_q == 2'd2) ? 2'd0 : pass_q + 2'd1;
      end
      if (ld) begin
        {l_q, r_q} <= ipv;
      end else if (st_q != StIdle) begin
        l_q <= r_q;
        r_q <= rf;
      end
      if (st_q != StIdle) begin
        if (dec) begin
          c_q <= f_ror(c_s, Rot[4'd15 - rnd_q]);
          d_q <= f_ror(d_s, Rot[4'd15 - rnd_q]);
        end else begin
          c_q <= c_s;
          d_q <= d_s;
        end
      end
      if (done && st_q == StSubkey) begin
        k1_q  <= k1n;
        k2_q  <= k2n;
        inm_q <= 1'b1;
      end else if (done && last_q) begin
        res_q <= fpv;
        cv_q  <= '0;
        inm_q <= 1'b0;
      end else if (done) begin
        cv_q <= fpv;
      end
      if (done && st_q == StCrypt && last_q) begin
        resv_q <= 1'b1;
      end else if (resv_q && res_rdy_i) begin
        resv_q <= 1'b0;
      end
    end
  end

endmodule

### rtl/tdes_cmac_chk.sv
`include "assert_macros.svh"
module tdes_cmac_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic empty,
  input logic pop,
  input logic [63:0] mac_o
);
  `CHK_NEXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(mac_o))
  `CHK_NEXT(a_gap, clk_i, rst_ni, !empty && pop, empty)
  `CHK_IMPL(a_rst, clk_i, rst_ni, $rose(rst_ni), empty)
endmodule

bind tdes_cmac_engine_unit tdes_cmac_chk u_chk (.*);
